// ===== design/paw_pkg.sv =====
// Shared types, constants and the arctangent table of the projection angle block.
package paw_pkg;

  // Default store geometry
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 8;

  // Accumulator width: up to 64 squared 17-bit differences, signed
  localparam int ACC_W = 40;

  // Angle constants in Q30; fixed-point one in Q30 and Q60, and the first square root bit
  localparam logic [33:0]        PI_Q30      = 34'd3373259426;
  localparam logic [33:0]        TWO_PI_Q30  = 34'd6746518852;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic [30:0]        ONE_Q30     = 31'h4000_0000;
  localparam logic [63:0]        ONE_Q60     = 64'h1000_0000_0000_0000;
  localparam logic [63:0]        SQRT_BIT0   = 64'h4000_0000_0000_0000;

  // Configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // Request kinds carried in tuser
  typedef enum logic [1:0] {
    REQ_COORD  = 2'd0,
    REQ_WEIGHT = 2'd1,
    REQ_QUERY  = 2'd2
  } req_e;

  // Query sequencer states
  typedef enum logic [4:0] {
    ST_IDLE, ST_ROW, ST_AB, ST_R, ST_D, ST_MAC, ST_CLASS,
    ST_SQA, ST_SQB, ST_DEN, ST_CCHK, ST_CDIV, ST_QSQ, ST_QSUB, ST_SQT,
    ST_CORD, ST_THETA, ST_WMUL, ST_WADD, ST_FDIV, ST_FDIVR, ST_DONE
  } state_e;

  // atan(2^-i) in Q30, rounded to nearest; beyond step 9 it is 2^(30-i)
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:    v = 30'd843314857;
      5'd1:    v = 30'd497837829;
      5'd2:    v = 30'd263043837;
      5'd3:    v = 30'd133525159;
      5'd4:    v = 30'd67021687;
      5'd5:    v = 30'd33543516;
      5'd6:    v = 30'd16775851;
      5'd7:    v = 30'd8388437;
      5'd8:    v = 30'd4194283;
      5'd9:    v = 30'd2097149;
      default: v = 30'd1 << (5'd30 - i);
    endcase
    return v;
  endfunction

endpackage

// ===== design/projection_angle_pair_weight.sv =====
// Top level: point store and weighted pair angle query sequencer.
//
//  channel   dir  handshake                 payload
//  cfg       in   cfg_we_i                  cfg_addr_i (index), cfg_wdata_i
//  s_axis    in   tvalid / tready           tuser req_type, tdata load/query fields
//  m_axis    out  tvalid / tready           tdata angle_mean
//
// A load is written as it is accepted. Per coordinate a query makes two store reads
// and four passes of the shared multiplier; a row with an angle then takes three
// 32-step square roots, a 30-step division (skipped if the cosine reaches one) and
// 30 CORDIC steps, and a 64-step division for the mean runs at the end.
// Reset clears control and configuration only; the stores are not cleared.
// The next request is taken while a result waits on m_axis; a finished query
// holds in its last state until the output register is free.
module projection_angle_pair_weight #(
  parameter int MAX_ROWS = paw_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = paw_pkg::MAX_COLS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // row_a[5:0], row_b[11:6], col_index[14:12], coord_value[30:15], row_weight[42:31]
  input  logic [47:0] s_axis_tdata_i,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // angle_mean[18:0]
  output logic [23:0] m_axis_tdata_o
);
  import paw_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = MAX_ROWS * (2 ** CW);
  localparam int RC_W  = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;
  localparam int CC_W  = ($clog2(MAX_COLS + 1) > 4) ? $clog2(MAX_COLS + 1) : 4;
  localparam int SUM_W = 46 + RW;
  localparam int TOT_W = 12 + RW;

  // Reduce a row field modulo MAX_ROWS by constant subtraction steps
  function automatic logic [RW-1:0] wrap_row(input logic [5:0] v);
    logic [16:0] t;
    t = {11'd0, v};
    for (int k = 5; k >= 0; k--) begin
      if (t >= 17'(MAX_ROWS << k)) t = t - 17'(MAX_ROWS << k);
    end
    return t[RW-1:0];
  endfunction

  // Input fields
  logic [5:0]         in_row_a, in_row_b;
  logic [2:0]         in_col;
  logic [15:0]        in_coord;
  logic [11:0]        in_weight;
  logic               in_acc;
  assign in_row_a  = s_axis_tdata_i[5:0];
  assign in_row_b  = s_axis_tdata_i[11:6];
  assign in_col    = s_axis_tdata_i[14:12];
  assign in_coord  = s_axis_tdata_i[30:15];
  assign in_weight = s_axis_tdata_i[42:31];
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;

  // Registers
  state_e state_q, state_d;
  logic [6:0]  rows_q, rows_d;
  logic [3:0]  cols_q, cols_d;
  logic        out_valid_q, out_valid_d;
  logic [18:0] out_q, out_d;
  logic [18:0] res_q, res_d;
  logic [RW-1:0]   a_q, a_d, b_q, b_d;
  logic [RC_W-1:0] r_q, r_d;
  logic [CC_W-1:0] s_q, s_d;
  logic [2:0]  ph_q, ph_d;
  logic signed [15:0] xa_q, xa_d, xb_q, xb_d;
  logic signed [16:0] da_q, da_d, db_q, db_d, dd_q, dd_d;
  logic signed [33:0] prod_q, prod_d;
  logic signed [ACC_W-1:0] dot_q, dot_d, la_q, la_d, lb_q, lb_d, dab_q, dab_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [TOT_W-1:0] total_q, total_d;
  logic [33:0] term_q, term_d;
  logic [45:0] wprod_q, wprod_d;
  logic [63:0] sq_v_q, sq_v_d, sq_r_q, sq_r_d, sq_bit_q, sq_bit_d;
  logic [4:0]  sq_cnt_q, sq_cnt_d;
  logic [31:0] sa_q, sa_d;
  logic [63:0] div_rem_q, div_rem_d, div_num_q, div_num_d;
  logic [63:0] div_quo_q, div_quo_d, div_den_q, div_den_d;
  logic [5:0]  div_cnt_q, div_cnt_d;
  logic [30:0] q_q, q_d;
  logic [61:0] qq_q, qq_d;
  logic        neg_q, neg_d;
  logic signed [35:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [34:0] cz_q, cz_d;
  logic [4:0]  ci_q, ci_d;

  // Memories and their read registers
  logic [15:0] coord_mem [DEPTH];
  logic [11:0] weight_mem [MAX_ROWS];
  logic [15:0] rd0_q, rd1_q;
  logic [11:0] w_rd_q;
  logic [AW-1:0] raddr0, raddr1, waddr;
  logic        rd_en, coord_we, weight_we;

  // Effective row and column counts
  logic [RC_W-1:0] rows_ext, nrows;
  logic [CC_W-1:0] cols_ext, ncols;
  assign rows_ext = RC_W'(rows_q);
  assign nrows    = (rows_ext > RC_W'(MAX_ROWS)) ? RC_W'(MAX_ROWS) : rows_ext;
  assign cols_ext = CC_W'(cols_q);
  assign ncols    = (cols_ext > CC_W'(MAX_COLS)) ? CC_W'(MAX_COLS) : cols_ext;

  logic last_row, last_col, both_zero, angle_case;
  assign last_row   = (r_q == nrows - RC_W'(1));
  assign last_col   = (s_q == ncols - CC_W'(1));
  assign both_zero  = (la_q == '0) && (lb_q == '0);
  assign angle_case = (la_q != '0) && (lb_q != '0) && (dab_q != '0);

  // Cosine numerator
  logic signed [ACC_W-1:0] abs_dot;
  logic [63:0] mag;
  assign abs_dot = (dot_q < 0) ? -dot_q : dot_q;
  assign mag     = 64'($unsigned(abs_dot)) << 24;

  // Square root step
  logic [63:0] sq_sum, sq_v_nx, sq_r_nx;
  logic        sq_ge, sq_last;
  assign sq_sum  = sq_r_q + sq_bit_q;
  assign sq_ge   = (sq_v_q >= sq_sum);
  assign sq_v_nx = sq_ge ? (sq_v_q - sq_sum) : sq_v_q;
  assign sq_r_nx = sq_ge ? ((sq_r_q >> 1) + sq_bit_q) : (sq_r_q >> 1);
  assign sq_last = (sq_cnt_q == 5'd31);

  // Restoring division step
  logic [63:0] dv_sh, dv_rem_nx, dv_quo_nx;
  logic        dv_ge;
  assign dv_sh     = {div_rem_q[62:0], div_num_q[63]};
  assign dv_ge     = (dv_sh >= div_den_q);
  assign dv_rem_nx = dv_ge ? (dv_sh - div_den_q) : dv_sh;
  assign dv_quo_nx = {div_quo_q[62:0], dv_ge};

  // CORDIC vectoring step
  logic signed [35:0] cx_sh, cy_sh;
  logic signed [34:0] c_at;
  logic signed [34:0] theta;
  assign cx_sh = cx_q >>> ci_q;
  assign cy_sh = cy_q >>> ci_q;
  assign c_at  = $signed({5'd0, atan_q30(ci_q)});
  assign theta = HALF_PI_Q30 + cz_q;

  // Shared multiplier operands
  logic signed [16:0] mul_a, mul_b;
  always_comb begin
    case (ph_q)
      3'd0:    begin mul_a = da_q; mul_b = db_q; end
      3'd1:    begin mul_a = da_q; mul_b = da_q; end
      3'd2:    begin mul_a = db_q; mul_b = db_q; end
      default: begin mul_a = dd_q; mul_b = dd_q; end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tuser_i == REQ_QUERY)) begin
          state_d = (nrows == '0) ? ST_FDIV : ST_ROW;
        end
      end
      ST_ROW:   state_d = (ncols == '0) ? ST_CLASS : ST_AB;
      ST_AB:    state_d = ST_R;
      ST_R:     state_d = ST_D;
      ST_D:     state_d = ST_MAC;
      ST_MAC: begin
        if (ph_q == 3'd4) state_d = last_col ? ST_CLASS : ST_AB;
      end
      ST_CLASS: state_d = (!both_zero && angle_case) ? ST_SQA : ST_WMUL;
      ST_SQA:   if (sq_last) state_d = ST_SQB;
      ST_SQB:   if (sq_last) state_d = ST_DEN;
      ST_DEN:   state_d = ST_CCHK;
      ST_CCHK:  state_d = (mag >= div_den_q) ? ST_QSQ : ST_CDIV;
      ST_CDIV:  if (div_cnt_q == 6'd29) state_d = ST_QSQ;
      ST_QSQ:   state_d = ST_QSUB;
      ST_QSUB:  state_d = ST_SQT;
      ST_SQT:   if (sq_last) state_d = ST_CORD;
      ST_CORD:  if (ci_q == 5'd29) state_d = ST_THETA;
      ST_THETA: state_d = ST_WMUL;
      ST_WMUL:  state_d = ST_WADD;
      ST_WADD:  state_d = last_row ? ST_FDIV : ST_ROW;
      ST_FDIV:  state_d = (total_q == '0) ? ST_DONE : ST_FDIVR;
      ST_FDIVR: if (div_cnt_q == 6'd63) state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Port and memory control outputs
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    rd_en     = (state_q == ST_AB) || (state_q == ST_R);
    raddr0    = (state_q == ST_R) ? {r_q[RW-1:0], s_q[CW-1:0]} : {a_q, s_q[CW-1:0]};
    raddr1    = {b_q, s_q[CW-1:0]};
    waddr     = {wrap_row(in_row_a), CW'(in_col)};
    coord_we  = in_acc && (s_axis_tuser_i == REQ_COORD) &&
                ({29'd0, in_col} < 32'(MAX_COLS));
    weight_we = in_acc && (s_axis_tuser_i == REQ_WEIGHT);
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_q};

  // Control: configuration and output register
  always_comb begin
    rows_d      = rows_q;
    cols_d      = cols_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_ROWS: rows_d = cfg_wdata_i;
        CFG_COLS: cols_d = cfg_wdata_i[3:0];
        default:  rows_d = rows_q;
      endcase
    end
    if (out_valid_q && m_axis_tready_i) out_valid_d = 1'b0;
    if ((state_q == ST_DONE) && !out_valid_q) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end
  end

  // Datapath: accumulate, root, divide, rotate
  always_comb begin
    a_d = a_q;  b_d = b_q;  r_d = r_q;  s_d = s_q;  ph_d = ph_q;
    xa_d = xa_q;  xb_d = xb_q;  da_d = da_q;  db_d = db_q;  dd_d = dd_q;
    prod_d = prod_q;
    dot_d = dot_q;  la_d = la_q;  lb_d = lb_q;  dab_d = dab_q;
    sum_d = sum_q;  total_d = total_q;  term_d = term_q;  wprod_d = wprod_q;
    sq_v_d = sq_v_q;  sq_r_d = sq_r_q;  sq_bit_d = sq_bit_q;  sq_cnt_d = sq_cnt_q;
    sa_d = sa_q;
    div_rem_d = div_rem_q;  div_num_d = div_num_q;  div_quo_d = div_quo_q;
    div_den_d = div_den_q;  div_cnt_d = div_cnt_q;
    q_d = q_q;  qq_d = qq_q;  neg_d = neg_q;
    cx_d = cx_q;  cy_d = cy_q;  cz_d = cz_q;  ci_d = ci_q;
    res_d = res_q;
    unique case (state_q)
      ST_IDLE: begin
        a_d     = wrap_row(in_row_a);
        b_d     = wrap_row(in_row_b);
        r_d     = '0;
        sum_d   = '0;
        total_d = '0;
      end
      ST_ROW: begin
        s_d = '0;  ph_d = '0;
        dot_d = '0;  la_d = '0;  lb_d = '0;  dab_d = '0;
      end
      ST_R: begin
        xa_d = $signed(rd0_q);
        xb_d = $signed(rd1_q);
      end
      ST_D: begin
        da_d = $signed({xa_q[15], xa_q}) - $signed({rd0_q[15], rd0_q});
        db_d = $signed({xb_q[15], xb_q}) - $signed({rd0_q[15], rd0_q});
        dd_d = $signed({xa_q[15], xa_q}) - $signed({xb_q[15], xb_q});
        ph_d = '0;
      end
      ST_MAC: begin
        prod_d = mul_a * mul_b;
        case (ph_q)
          3'd1:    dot_d = dot_q + ACC_W'(prod_q);
          3'd2:    la_d  = la_q + ACC_W'(prod_q);
          3'd3:    lb_d  = lb_q + ACC_W'(prod_q);
          3'd4:    dab_d = dab_q + ACC_W'(prod_q);
          default: dot_d = dot_q;
        endcase
        if (ph_q == 3'd4) begin
          ph_d = '0;
          s_d  = s_q + CC_W'(1);
        end else begin
          ph_d = ph_q + 3'd1;
        end
      end
      ST_CLASS: begin
        term_d   = both_zero ? TWO_PI_Q30 : PI_Q30;
        neg_d    = (dot_q < 0);
        sq_v_d   = 64'($unsigned(la_q)) << 24;
        sq_r_d   = '0;
        sq_bit_d = SQRT_BIT0;
        sq_cnt_d = '0;
      end
      ST_SQA, ST_SQB, ST_SQT: begin
        sq_v_d   = sq_v_nx;
        sq_r_d   = sq_r_nx;
        sq_bit_d = sq_bit_q >> 2;
        sq_cnt_d = sq_cnt_q + 5'd1;
        if (sq_last && (state_q == ST_SQA)) begin
          sa_d     = sq_r_nx[31:0];
          sq_v_d   = 64'($unsigned(lb_q)) << 24;
          sq_r_d   = '0;
          sq_bit_d = SQRT_BIT0;
          sq_cnt_d = '0;
        end
        if (sq_last && (state_q == ST_SQT)) begin
          cx_d = $signed({4'd0, sq_r_nx[31:0]});
          cy_d = neg_q ? -$signed({5'd0, q_q}) : $signed({5'd0, q_q});
          cz_d = '0;
          ci_d = '0;
        end
      end
      ST_DEN: begin
        div_den_d = 64'(sa_q) * 64'(sq_r_q[31:0]);
      end
      ST_CCHK: begin
        q_d       = ONE_Q30;
        div_rem_d = mag;
        div_num_d = '0;
        div_quo_d = '0;
        div_cnt_d = '0;
      end
      ST_CDIV, ST_FDIVR: begin
        div_rem_d = dv_rem_nx;
        div_num_d = div_num_q << 1;
        div_quo_d = dv_quo_nx;
        div_cnt_d = div_cnt_q + 6'd1;
        if (state_q == ST_CDIV) q_d = dv_quo_nx[30:0];
        else res_d = dv_quo_nx[32:14];
      end
      ST_QSQ: begin
        qq_d = 62'(q_q) * 62'(q_q);
      end
      ST_QSUB: begin
        sq_v_d   = ONE_Q60 - 64'(qq_q);
        sq_r_d   = '0;
        sq_bit_d = SQRT_BIT0;
        sq_cnt_d = '0;
      end
      ST_CORD: begin
        if (cy_q >= 0) begin
          cx_d = cx_q + cy_sh;
          cy_d = cy_q - cx_sh;
          cz_d = cz_q + c_at;
        end else begin
          cx_d = cx_q - cy_sh;
          cy_d = cy_q + cx_sh;
          cz_d = cz_q - c_at;
        end
        ci_d = ci_q + 5'd1;
      end
      ST_THETA: begin
        if (theta < 0) term_d = '0;
        else if (theta > $signed({1'b0, PI_Q30})) term_d = PI_Q30;
        else term_d = 34'($unsigned(theta));
      end
      ST_WMUL: begin
        wprod_d = 46'(term_q) * 46'(w_rd_q);
      end
      ST_WADD: begin
        sum_d   = sum_q + SUM_W'(wprod_q);
        total_d = total_q + TOT_W'(w_rd_q);
        r_d     = r_q + RC_W'(1);
      end
      ST_FDIV: begin
        res_d     = '0;
        div_rem_d = '0;
        div_num_d = 64'(sum_q);
        div_den_d = 64'(total_q);
        div_quo_d = '0;
        div_cnt_d = '0;
      end
      default: res_d = res_q;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rows_q      <= 7'd1;
      cols_q      <= 4'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rows_q      <= rows_d;
      cols_q      <= cols_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;  res_q <= res_d;
    a_q <= a_d;  b_q <= b_d;  r_q <= r_d;  s_q <= s_d;  ph_q <= ph_d;
    xa_q <= xa_d;  xb_q <= xb_d;  da_q <= da_d;  db_q <= db_d;  dd_q <= dd_d;
    prod_q <= prod_d;
    dot_q <= dot_d;  la_q <= la_d;  lb_q <= lb_d;  dab_q <= dab_d;
    sum_q <= sum_d;  total_q <= total_d;  term_q <= term_d;  wprod_q <= wprod_d;
    sq_v_q <= sq_v_d;  sq_r_q <= sq_r_d;  sq_bit_q <= sq_bit_d;  sq_cnt_q <= sq_cnt_d;
    sa_q <= sa_d;
    div_rem_q <= div_rem_d;  div_num_q <= div_num_d;  div_quo_q <= div_quo_d;
    div_den_q <= div_den_d;  div_cnt_q <= div_cnt_d;
    q_q <= q_d;  qq_q <= qq_d;  neg_q <= neg_d;
    cx_q <= cx_d;  cy_q <= cy_d;  cz_q <= cz_d;  ci_q <= ci_d;
  end

  // Coordinate store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (coord_we) coord_mem[waddr] <= in_coord;
    if (rd_en) begin
      rd0_q <= coord_mem[raddr0];
      rd1_q <= coord_mem[raddr1];
    end
  end

  // Weight store: read once at the start of each reference row
  always_ff @(posedge clk_i) begin
    if (weight_we) weight_mem[wrap_row(in_row_a)] <= in_weight;
    if (state_q == ST_ROW) w_rd_q <= weight_mem[r_q[RW-1:0]];
  end

  // Divider remainder stays below the divisor while stepping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CDIV) || (state_q == ST_FDIVR)) |-> (div_rem_q < div_den_q))
    else $error("divider remainder not below divisor");

  // A result appears only from the finishing state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result loaded outside finishing state");

  // Cosine magnitude never exceeds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QSQ) |-> (q_q <= ONE_Q30))
    else $error("cosine magnitude above one");

endmodule

// ===== dv/projection_angle_pair_weight_test.sv =====
// Testbench for projection_angle_pair_weight: stream stimulus, predictor and result checks.
`timescale 1ns / 100ps

module projection_angle_pair_weight_test;
  import paw_pkg::*;

  localparam logic [1:0] REQ_IGNORED = 2'd3;
  localparam int ROWS = 64;
  localparam int COLS = 8;

  typedef struct {
    logic [1:0]  kind;
    logic [5:0]  row_a;
    logic [5:0]  row_b;
    logic [2:0]  col;
    logic [15:0] coord;
    logic [11:0] weight;
  } word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_addr_i = CFG_ROWS;
  logic [6:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;

  projection_angle_pair_weight i_dut (.*);

  // Predictor copy of the stores and registers
  logic [15:0] coord_mem [ROWS*COLS];
  logic [11:0] weight_mem [ROWS];
  bit          coord_set [ROWS][COLS];
  bit          weight_set [ROWS];
  int unsigned rows_reg = 1;
  int unsigned cols_reg = 1;
  longint      atan_tab [30];

  word_t       pending_words [$];
  logic [18:0] mean_q [$];
  int          n_pushed = 0;
  int          n_taken = 0;
  int          n_errors = 0;
  int          gap_cnt = 0;
  int          stall_cnt = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int rand_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive the request stream from the pending queue
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && !s_axis_tready_o) begin
        // hold the current word
      end else if (gap_cnt > 0) begin
        s_axis_tvalid_i <= 1'b0;
        gap_cnt <= gap_cnt - 1;
      end else if (pending_words.size() > 0) begin
        word_t w;
        w = pending_words.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tuser_i  <= w.kind;
        s_axis_tdata_i  <= {5'd0, w.weight, w.coord, w.col, w.row_b, w.row_a};
        gap_cnt <= rand_gap();
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_cnt > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_cnt <= stall_cnt - 1;
      end else begin
        m_axis_tready_i <= 1'b1;
        if ($urandom_range(0, 99) < 12) stall_cnt <= rand_gap() + 1;
      end
    end
  end

  // Count accepted requests and check results in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) n_taken <= n_taken + 1;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (mean_q.size() == 0) begin
          $error("unexpected result angle_mean=%0d", m_axis_tdata_o[18:0]);
          n_errors <= n_errors + 1;
        end else begin
          logic [18:0] want;
          want = mean_q.pop_front();
          if (m_axis_tdata_o[18:0] !== want) begin
            $error("angle_mean mismatch: expected %0d, actual %0d", want,
                   m_axis_tdata_o[18:0]);
            n_errors <= n_errors + 1;
          end
        end
      end
    end
  end

  function automatic longint signed_coord(int r, int c);
    return longint'($signed(coord_mem[r*COLS + c]));
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void build_atan_tab();
    bit [63:0] pos, neg, term;
    atan_tab[0] = longint'((64'h3243F6A8885A308D + 64'h8000_0000) >> 32);
    for (int i = 1; i < 30; i++) begin
      pos = 0;
      neg = 0;
      for (int k = 0; i * (2*k + 1) <= 62; k++) begin
        term = (64'd1 << (62 - i*(2*k + 1))) / (2*k + 1);
        if (k & 1) neg += term;
        else pos += term;
      end
      atan_tab[i] = longint'(((pos - neg) + 64'h8000_0000) >> 32);
    end
  endfunction

  // pi - acos(cos) at the reference point, Q30
  function automatic longint far_angle(longint dot, longint la, longint lb);
    bit [63:0] mag, den, q;
    longint x, y, z, dx, dy, theta;
    mag = (dot < 0 ? -dot : dot);
    mag = mag << 24;
    den = int_sqrt(la << 24) * int_sqrt(lb << 24);
    q = 0;
    if (mag >= den) begin
      q = 64'd1 << 30;
    end else begin
      for (int i = 0; i < 30; i++) begin
        mag = mag << 1;
        q = q << 1;
        if (mag >= den) begin
          mag = mag - den;
          q = q | 1;
        end
      end
    end
    x = longint'(int_sqrt((64'd1 << 60) - q*q));
    y = dot < 0 ? -longint'(q) : longint'(q);
    z = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_tab[i];
      end
    end
    theta = longint'(HALF_PI_Q30) + z;
    if (theta < 0) theta = 0;
    if (theta > longint'(PI_Q30)) theta = longint'(PI_Q30);
    return theta;
  endfunction

  function automatic logic [18:0] predict_mean(int a, int b);
    int nr, nc;
    bit [63:0] sum, total, w;
    longint dot, la, lb, dab, da, db, d, term;
    nr = rows_reg > ROWS ? ROWS : rows_reg;
    nc = cols_reg > COLS ? COLS : cols_reg;
    sum = 0;
    total = 0;
    for (int r = 0; r < nr; r++) begin
      dot = 0; la = 0; lb = 0; dab = 0;
      w = weight_mem[r];
      for (int s = 0; s < nc; s++) begin
        da = signed_coord(a, s) - signed_coord(r, s);
        db = signed_coord(b, s) - signed_coord(r, s);
        d  = signed_coord(a, s) - signed_coord(b, s);
        dot += da*db; la += da*da; lb += db*db; dab += d*d;
      end
      if (la == 0 && lb == 0) term = 2 * longint'(PI_Q30);
      else if (la != 0 && lb != 0 && dab != 0) term = far_angle(dot, la, lb);
      else term = longint'(PI_Q30);
      sum += 64'(term) * w;
      total += w;
    end
    if (total == 0) return '0;
    return 19'((sum / total) >> 14);
  endfunction

  // Queue one word, updating the predictor and the expected results
  function automatic void push_word(logic [1:0] kind, int a, int b, int c,
                                    logic [15:0] v, logic [11:0] wt);
    word_t w;
    w = '{kind, 6'(a), 6'(b), 3'(c), v, wt};
    if (kind == REQ_COORD) begin
      coord_mem[a*COLS + c] = v;
      coord_set[a][c] = 1'b1;
    end else if (kind == REQ_WEIGHT) begin
      weight_mem[a] = wt;
      weight_set[a] = 1'b1;
    end else if (kind == REQ_QUERY) begin
      mean_q.push_back(predict_mean(a, b));
    end
    pending_words.push_back(w);
    n_pushed++;
  endfunction

  function automatic logic [15:0] rand_coord();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'h7FFF;
    if (p == 1) return 16'h8000;
    if (p < 6) return 16'($signed($urandom_range(0, 16)) - 8);
    return 16'($urandom);
  endfunction

  function automatic logic [11:0] rand_weight();
    return $urandom_range(0, 9) == 0 ? 12'hFFF : 12'($urandom_range(1, 4095));
  endfunction

  function automatic bit row_ready(int r, int nc);
    for (int c = 0; c < nc; c++)
      if (!coord_set[r][c]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_row(int span, int nc);
    int r;
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, span - 1);
    r = $urandom_range(0, ROWS - 1);
    return row_ready(r, nc) ? r : 0;
  endfunction

  task automatic drain();
    while (n_taken != n_pushed || mean_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  // Write both registers once every queued word has been taken and answered
  task automatic write_cfg(int rows_v, int cols_v);
    drain();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_ROWS;
    cfg_wdata_i <= 7'(rows_v);
    @(posedge clk_i);
    cfg_addr_i  <= CFG_COLS;
    cfg_wdata_i <= 7'(cols_v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rows_reg = rows_v & 7'h7F;
    cols_reg = cols_v & 4'hF;
  endtask

  // One setting: fill what the setting reads, then mix loads, ignored words and queries
  task automatic run_phase(int rows_v, int cols_v, int n_query, bit pause_mid);
    int nr, nc, span, a, b, src;
    write_cfg(rows_v, cols_v);
    nr = rows_reg > ROWS ? ROWS : rows_reg;
    nc = cols_reg > COLS ? COLS : cols_reg;
    span = nr < 2 ? 2 : nr;
    for (int r = 0; r < span; r++) begin
      for (int c = 0; c < nc; c++)
        if (!coord_set[r][c]) push_word(REQ_COORD, r, 0, c, rand_coord(), '0);
      if (r < nr && !weight_set[r]) push_word(REQ_WEIGHT, r, 0, 0, '0, rand_weight());
    end
    for (int q = 0; q < n_query; q++) begin
      if (pause_mid && q == n_query / 2) drain();
      repeat ($urandom_range(0, 2)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: push_word(REQ_COORD, $urandom_range(0, ROWS - 1), $urandom_range(0, 63),
                                $urandom_range(0, COLS - 1), rand_coord(), 12'($urandom));
          4, 5: push_word(REQ_WEIGHT, $urandom_range(0, span - 1), $urandom_range(0, 63),
                          $urandom_range(0, 7), 16'($urandom), rand_weight());
          6: push_word(REQ_IGNORED, $urandom_range(0, 63), $urandom_range(0, 63),
                       $urandom_range(0, 7), 16'($urandom), 12'($urandom));
          default: begin
            // copy one point onto another so that points coincide
            a = $urandom_range(0, span - 1);
            src = $urandom_range(0, span - 1);
            for (int c = 0; c < nc; c++)
              push_word(REQ_COORD, a, 0, c, coord_mem[src*COLS + c], '0);
          end
        endcase
      end
      a = pick_row(span, nc);
      b = $urandom_range(0, 3) == 0 ? a : pick_row(span, nc);
      push_word(REQ_QUERY, a, b, $urandom_range(0, 7), 16'($urandom), 12'($urandom));
    end
  endtask

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    build_atan_tab();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extreme coordinates and weights, coincident points, ignored kind
    write_cfg(3, 2);
    push_word(REQ_COORD, 0, 0, 0, 16'h7FFF, '0);
    push_word(REQ_COORD, 0, 0, 1, 16'h8000, '0);
    push_word(REQ_COORD, 1, 0, 0, 16'h8000, '0);
    push_word(REQ_COORD, 1, 0, 1, 16'h0001, '0);
    push_word(REQ_COORD, 2, 0, 0, 16'h7FFF, '0);
    push_word(REQ_COORD, 2, 0, 1, 16'h8000, '0);
    push_word(REQ_COORD, 63, 63, 7, 16'hFFFF, 12'hFFF);
    push_word(REQ_WEIGHT, 0, 0, 0, '0, 12'hFFF);
    push_word(REQ_WEIGHT, 1, 0, 0, '0, 12'h001);
    push_word(REQ_WEIGHT, 2, 0, 0, '0, 12'h800);
    push_word(REQ_WEIGHT, 63, 0, 0, '0, 12'hFFF);
    push_word(REQ_IGNORED, 63, 63, 7, 16'hFFFF, 12'hFFF);
    push_word(REQ_QUERY, 0, 0, 0, '0, '0);
    push_word(REQ_QUERY, 0, 1, 0, '0, '0);
    push_word(REQ_QUERY, 1, 0, 0, '0, '0);
    push_word(REQ_QUERY, 1, 1, 0, '0, '0);
    push_word(REQ_QUERY, 0, 2, 0, '0, '0);
    push_word(REQ_QUERY, 2, 1, 0, '0, '0);
    push_word(REQ_COORD, 2, 0, 1, 16'h0000, '0);
    push_word(REQ_QUERY, 0, 1, 0, '0, '0);
    push_word(REQ_QUERY, 1, 2, 0, '0, '0);
    drain();

    // Random phases over a range of settings, extremes included
    run_phase(3, 8, 4, 1'b1);
    run_phase(64, 1, 3, 1'b0);
    run_phase(0, 3, 2, 1'b0);
    run_phase(127, 1, 2, 1'b0);
    run_phase(5, 15, 4, 1'b0);
    run_phase(8, 2, 5, 1'b0);
    run_phase(1, 4, 3, 1'b0);
    run_phase(2, 0, 3, 1'b0);
    run_phase(4, 5, 5, 1'b0);
    run_phase(6, 7, 4, 1'b0);
    run_phase(3, 3, 5, 1'b0);
    drain();

    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
